@@ hw/rtl/p1the_pkg.sv @@
// ----------------------------------------------------------------------------
// p1the_pkg
// Shared widths, lane map and sideband type of the P1 triangle element matrix.
// ----------------------------------------------------------------------------
package p1the_pkg;

    localparam int FRAC_BITS = 16;

    localparam int CW   = 32;          // input field width
    localparam int NIN  = 7;           // input fields
    localparam int DFW  = CW + 1;      // coordinate difference
    localparam int PRW  = 2 * DFW;     // signed product
    localparam int DSW  = PRW + 1;     // signed D or G
    localparam int MGW  = PRW;         // magnitude of D or G
    localparam int HW   = 33;          // split of a magnitude for multiply
    localparam int PPW  = HW + CW;     // partial product
    localparam int DVW  = MGW + 1;     // divisor (2|D|)
    localparam int RW   = DVW + 1;     // remainder
    localparam int NW   = MGW + CW;    // numerator / quotient
    localparam int NSL  = 6;           // stiffness lanes (upper triangle)
    localparam int NL   = NSL;         // divider lanes
    localparam int QW   = 64;          // mass term before and after divide by 3
    localparam int SSW  = NW + 2;      // signed rounded term
    localparam int SUMW = SSW + 1;     // sum of two terms
    localparam int OW   = 48;          // output entry
    localparam int NE   = 9;           // matrix entries
    localparam int MSH  = 2 * FRAC_BITS + 3;

    localparam logic [NW+1:0]  MASS_HALF = (NW+2)'(3) << (2 * FRAC_BITS + 2);
    localparam logic [CW-1:0]  DTR_RESET = CW'(65536);

    // x / 3 = (x * (2^65 + 1) / 3) >> 65 for any 64-bit x
    localparam logic [CW-1:0]  REC3_LO   = 32'hAAAA_AAAB;
    localparam logic [CW-1:0]  REC3_HI   = 32'hAAAA_AAAA;
    localparam int             REC3_SH   = 65;

    localparam logic signed [SUMW-1:0] SUM_MAX = SUMW'(64'sd140737488355327);
    localparam logic signed [SUMW-1:0] SUM_MIN = -SUMW'(64'sd140737488355328);
    localparam logic [OW-1:0] OUT_MAX = {1'b0, {(OW-1){1'b1}}};
    localparam logic [OW-1:0] OUT_MIN = {1'b1, {(OW-1){1'b0}}};

    // lane k holds G(PI[k], PJ[k])
    localparam int PI [NSL] = '{0, 0, 0, 1, 1, 2};
    localparam int PJ [NSL] = '{0, 1, 2, 1, 2, 2};
    // entry e (row-major) reads stiffness lane LANE_OF[e]
    localparam int LANE_OF [NE] = '{0, 1, 2, 1, 3, 4, 2, 4, 5};
    localparam logic [NE-1:0] DIAG = 9'b100_010_001;

    typedef struct packed {
        logic [1:0][QW-1:0] mass;      // off-diagonal, diagonal mass magnitude
        logic               degen;
        logic               dneg;
        logic [NSL-1:0]     gneg;
    } t_side;

endpackage

@@ hw/rtl/p1_triangle_heat_element_matrix.sv @@
// ----------------------------------------------------------------------------
// p1_triangle_heat_element_matrix
// P1 triangle stiffness plus time-step mass element matrix, Q16.16.
// ----------------------------------------------------------------------------
// Input beats on the s-side stream carry x0,y0,x1,y1,x2,y2,conductivity.
// Each beat yields one m-side beat with k00..k22 in tdata (row-major) and
// the degenerate flag in tuser.
// The cfg channel writes 1/dt (Q16.16); it is always ready and is sampled
// by each item as it enters. Write it only while the block is empty.
// The pipeline has 7 front stages (differences, products, area and
// dot products, split multiplies, numerators, two for the mass divide by
// three), 98 stages of the one-bit-per-stage restoring divider (numerator
// width), and 2 output stages.
// Throughput is one beat per cycle while the receiver accepts results.
// Reset clears all valid bits and sets 1/dt to 1.0.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and s-side tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module p1_triangle_heat_element_matrix (
    input  logic                                        i_clk,
    input  logic                                        i_rst_n,
    input  logic                                        i_s_tvalid,
    output logic                                        o_s_tready,
    // x0, y0, x1, y1, x2, y2, conductivity
    input  logic [p1the_pkg::NIN*p1the_pkg::CW-1:0]     i_s_tdata,
    output logic                                        o_m_tvalid,
    input  logic                                        i_m_tready,
    // k00, k01, k02, k10, k11, k12, k20, k21, k22
    output logic [p1the_pkg::NE*p1the_pkg::OW-1:0]      o_m_tdata,
    // degenerate
    output logic                                        o_m_tuser,
    input  logic                                        i_cfg_valid,
    output logic                                        o_cfg_ready,
    input  logic [p1the_pkg::CW-1:0]                    i_cfg_data
);

    logic [p1the_pkg::CW-1:0] r_dtr;
    logic w_ce;

    logic                                          f_valid;
    logic [p1the_pkg::NL-1:0][p1the_pkg::NW-1:0]   f_num;
    logic [p1the_pkg::NL-1:0][p1the_pkg::DVW-1:0]  f_div;
    p1the_pkg::t_side                              f_side;

    logic                                          d_valid;
    logic [p1the_pkg::NL-1:0][p1the_pkg::NW-1:0]   d_quo;
    logic [p1the_pkg::NL-1:0][p1the_pkg::RW-1:0]   d_rem;
    logic [p1the_pkg::NL-1:0][p1the_pkg::DVW-1:0]  d_div;
    p1the_pkg::t_side                              d_side;

    logic [p1the_pkg::NE-1:0][p1the_pkg::OW-1:0]   b_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dtr <= p1the_pkg::DTR_RESET;
        end else if (i_cfg_valid) begin
            r_dtr <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign w_ce        = !o_m_tvalid || i_m_tready;
    assign o_s_tready  = w_ce;

    p1the_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (i_s_tvalid),
        .i_data  (i_s_tdata),
        .i_dtr   (r_dtr),
        .o_valid (f_valid),
        .o_num   (f_num),
        .o_div   (f_div),
        .o_side  (f_side)
    );

    p1the_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (f_valid),
        .i_num   (f_num),
        .i_div   (f_div),
        .i_side  (f_side),
        .o_valid (d_valid),
        .o_quo   (d_quo),
        .o_rem   (d_rem),
        .o_div   (d_div),
        .o_side  (d_side)
    );

    p1the_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_valid (d_valid),
        .i_quo   (d_quo),
        .i_rem   (d_rem),
        .i_div   (d_div),
        .i_side  (d_side),
        .o_valid (o_m_tvalid),
        .o_k     (b_k),
        .o_degen (o_m_tuser)
    );

    assign o_m_tdata = b_k;

endmodule

@@ hw/rtl/p1the_front.sv @@
// ----------------------------------------------------------------------------
// p1the_front
// Seven-stage front end: differences, products, area and dot products,
// split multiplies by conductivity and 1/dt, numerator assembly, and the
// mass divide by three by reciprocal multiply.
// ----------------------------------------------------------------------------
module p1the_front (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_ce,
    input  logic                                          i_valid,
    input  logic [p1the_pkg::NIN*p1the_pkg::CW-1:0]       i_data,
    input  logic [p1the_pkg::CW-1:0]                      i_dtr,
    output logic                                          o_valid,
    output logic [p1the_pkg::NL-1:0][p1the_pkg::NW-1:0]   o_num,
    output logic [p1the_pkg::NL-1:0][p1the_pkg::DVW-1:0]  o_div,
    output p1the_pkg::t_side                              o_side
);

    localparam int CW  = p1the_pkg::CW;
    localparam int DFW = p1the_pkg::DFW;
    localparam int PRW = p1the_pkg::PRW;
    localparam int DSW = p1the_pkg::DSW;
    localparam int MGW = p1the_pkg::MGW;
    localparam int HW  = p1the_pkg::HW;
    localparam int PPW = p1the_pkg::PPW;
    localparam int NW  = p1the_pkg::NW;
    localparam int DVW = p1the_pkg::DVW;
    localparam int NSL = p1the_pkg::NSL;
    localparam int NL  = p1the_pkg::NL;
    localparam int QW  = p1the_pkg::QW;

    logic [6:0] r_v;

    // stage 1
    logic signed [DFW-1:0] w_c [6];
    logic signed [DFW-1:0] n_df [4], r_df [4];
    logic signed [DFW-1:0] n_gx [3], r_gx [3];
    logic signed [DFW-1:0] n_gy [3], r_gy [3];
    logic [CW-1:0] r_lam1, r_dtr1;

    always_comb begin
        for (int k = 0; k < 6; k++) begin
            w_c[k] = {i_data[k*CW+CW-1], i_data[k*CW +: CW]};
        end
        n_df[0] = w_c[2] - w_c[0];
        n_df[1] = w_c[5] - w_c[1];
        n_df[2] = w_c[4] - w_c[0];
        n_df[3] = w_c[3] - w_c[1];
        n_gx[0] = w_c[3] - w_c[5];
        n_gy[0] = w_c[4] - w_c[2];
        n_gx[1] = w_c[5] - w_c[1];
        n_gy[1] = w_c[0] - w_c[4];
        n_gx[2] = w_c[1] - w_c[3];
        n_gy[2] = w_c[2] - w_c[0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_df   <= n_df;
            r_gx   <= n_gx;
            r_gy   <= n_gy;
            r_lam1 <= i_data[6*CW +: CW];
            r_dtr1 <= i_dtr;
        end
    end

    // stage 2
    logic signed [PRW-1:0] n_pd [2], r_pd [2];
    logic signed [PRW-1:0] n_px [NSL], r_px [NSL];
    logic signed [PRW-1:0] n_py [NSL], r_py [NSL];
    logic [CW-1:0] r_lam2, r_dtr2;

    always_comb begin
        n_pd[0] = r_df[0] * r_df[1];
        n_pd[1] = r_df[2] * r_df[3];
        for (int k = 0; k < NSL; k++) begin
            n_px[k] = r_gx[p1the_pkg::PI[k]] * r_gx[p1the_pkg::PJ[k]];
            n_py[k] = r_gy[p1the_pkg::PI[k]] * r_gy[p1the_pkg::PJ[k]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_pd   <= n_pd;
            r_px   <= n_px;
            r_py   <= n_py;
            r_lam2 <= r_lam1;
            r_dtr2 <= r_dtr1;
        end
    end

    // stage 3
    logic signed [DSW-1:0] w_d, w_dn;
    logic signed [DSW-1:0] w_g [NSL], w_gn [NSL];
    logic [MGW-1:0] n_dmag, r_dmag;
    logic [MGW-1:0] n_gmag [NSL], r_gmag [NSL];
    p1the_pkg::t_side n_side3, r_side3, r_side4;
    logic [CW-1:0] r_lam3, r_dtr3;

    always_comb begin
        w_d  = {r_pd[0][PRW-1], r_pd[0]} - {r_pd[1][PRW-1], r_pd[1]};
        w_dn = -w_d;
        n_side3.mass  = '0;
        n_side3.degen = (w_d == '0);
        n_side3.dneg  = w_d[DSW-1];
        n_dmag = w_d[DSW-1] ? w_dn[MGW-1:0] : w_d[MGW-1:0];
        for (int k = 0; k < NSL; k++) begin
            w_g[k]  = {r_px[k][PRW-1], r_px[k]} + {r_py[k][PRW-1], r_py[k]};
            w_gn[k] = -w_g[k];
            n_side3.gneg[k] = w_g[k][DSW-1];
            n_gmag[k] = w_g[k][DSW-1] ? w_gn[k][MGW-1:0] : w_g[k][MGW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_dmag  <= n_dmag;
            r_gmag  <= n_gmag;
            r_side3 <= n_side3;
            r_lam3  <= r_lam2;
            r_dtr3  <= r_dtr2;
        end
    end

    // stage 4: split multiplies
    logic [PPW-1:0] r_glo [NSL], r_ghi [NSL];
    logic [PPW-1:0] r_mlo, r_mhi;
    logic [DVW-1:0] r_twod4;

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int k = 0; k < NSL; k++) begin
                r_glo[k] <= PPW'(r_gmag[k][HW-1:0]) * PPW'(r_lam3);
                r_ghi[k] <= PPW'(r_gmag[k][MGW-1:HW]) * PPW'(r_lam3);
            end
            r_mlo   <= PPW'(r_dmag[HW-1:0]) * PPW'(r_dtr3);
            r_mhi   <= PPW'(r_dmag[MGW-1:HW]) * PPW'(r_dtr3);
            r_twod4 <= {r_dmag, 1'b0};
            r_side4 <= r_side3;
        end
    end

    // stage 5: numerators, mass pre-shift with rounding offset
    logic [NW+1:0] w_m1, w_m2, w_t1, w_t2;
    logic [NL-1:0][NW-1:0]  n_num, r_num5, r_num6, r_num;
    logic [NL-1:0][DVW-1:0] n_div, r_div5, r_div6, r_div;
    logic [QW-1:0] n_t [2], r_t [2];
    p1the_pkg::t_side r_side5, r_side6, n_side7, r_side7;

    always_comb begin
        for (int k = 0; k < NL; k++) begin
            n_num[k] = NW'(r_glo[k]) + (NW'(r_ghi[k]) << HW);
            n_div[k] = r_twod4;
        end
        w_m1 = (NW+2)'(r_mlo) + ((NW+2)'(r_mhi) << HW);
        w_m2 = w_m1 << 1;
        w_t1 = (w_m1 + p1the_pkg::MASS_HALF) >> p1the_pkg::MSH;
        w_t2 = (w_m2 + p1the_pkg::MASS_HALF) >> p1the_pkg::MSH;
        n_t[0] = w_t1[QW-1:0];
        n_t[1] = w_t2[QW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_num5  <= n_num;
            r_div5  <= n_div;
            r_t     <= n_t;
            r_side5 <= r_side4;
        end
    end

    // stage 6: partial products of t times the reciprocal of three
    logic [2*CW-1:0] r_pp [2][4];

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            for (int l = 0; l < 2; l++) begin
                r_pp[l][0] <= (2*CW)'(r_t[l][CW-1:0]) * (2*CW)'(p1the_pkg::REC3_LO);
                r_pp[l][1] <= (2*CW)'(r_t[l][CW-1:0]) * (2*CW)'(p1the_pkg::REC3_HI);
                r_pp[l][2] <= (2*CW)'(r_t[l][QW-1:CW]) * (2*CW)'(p1the_pkg::REC3_LO);
                r_pp[l][3] <= (2*CW)'(r_t[l][QW-1:CW]) * (2*CW)'(p1the_pkg::REC3_HI);
            end
            r_num6  <= r_num5;
            r_div6  <= r_div5;
            r_side6 <= r_side5;
        end
    end

    // stage 7: t / 3
    logic [4*CW-1:0] w_prod [2];

    always_comb begin
        n_side7 = r_side6;
        for (int l = 0; l < 2; l++) begin
            w_prod[l] = (4*CW)'(r_pp[l][0])
                      + ((4*CW)'(r_pp[l][1]) << CW)
                      + ((4*CW)'(r_pp[l][2]) << CW)
                      + ((4*CW)'(r_pp[l][3]) << (2*CW));
            n_side7.mass[l] = QW'(w_prod[l][4*CW-1:p1the_pkg::REC3_SH]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_num   <= r_num6;
            r_div   <= r_div6;
            r_side7 <= n_side7;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_ce) begin
            r_v <= {r_v[5:0], i_valid};
        end
    end

    assign o_valid = r_v[6];
    assign o_num   = r_num;
    assign o_div   = r_div;
    assign o_side  = r_side7;

endmodule

@@ hw/rtl/p1the_divider.sv @@
// ----------------------------------------------------------------------------
// p1the_divider
// Pipelined restoring divider, one quotient bit per stage, six lanes.
// ----------------------------------------------------------------------------
module p1the_divider (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_ce,
    input  logic                                          i_valid,
    input  logic [p1the_pkg::NL-1:0][p1the_pkg::NW-1:0]   i_num,
    input  logic [p1the_pkg::NL-1:0][p1the_pkg::DVW-1:0]  i_div,
    input  p1the_pkg::t_side                              i_side,
    output logic                                          o_valid,
    output logic [p1the_pkg::NL-1:0][p1the_pkg::NW-1:0]   o_quo,
    output logic [p1the_pkg::NL-1:0][p1the_pkg::RW-1:0]   o_rem,
    output logic [p1the_pkg::NL-1:0][p1the_pkg::DVW-1:0]  o_div,
    output p1the_pkg::t_side                              o_side
);

    localparam int NW  = p1the_pkg::NW;
    localparam int RW  = p1the_pkg::RW;
    localparam int DVW = p1the_pkg::DVW;
    localparam int NL  = p1the_pkg::NL;

    logic [NL-1:0][RW-1:0]  r_rem  [NW];
    logic [NL-1:0][NW-1:0]  r_nq   [NW];
    logic [NL-1:0][DVW-1:0] r_div  [NW];
    p1the_pkg::t_side       r_side [NW];
    logic [NW-1:0]          r_v;

    for (genvar gs = 0; gs < NW; gs++) begin : g_stage
        logic [NL-1:0][RW-1:0]  w_rem;
        logic [NL-1:0][NW-1:0]  w_nq;
        logic [NL-1:0][DVW-1:0] w_div;
        p1the_pkg::t_side       w_side;
        logic                   w_v;
        logic [NL-1:0][RW-1:0]  n_rem;
        logic [NL-1:0][NW-1:0]  n_nq;

        if (gs == 0) begin : g_first
            assign w_rem  = '0;
            assign w_nq   = i_num;
            assign w_div  = i_div;
            assign w_side = i_side;
            assign w_v    = i_valid;
        end else begin : g_next
            assign w_rem  = r_rem[gs-1];
            assign w_nq   = r_nq[gs-1];
            assign w_div  = r_div[gs-1];
            assign w_side = r_side[gs-1];
            assign w_v    = r_v[gs-1];
        end

        always_comb begin
            logic [RW-1:0] t;
            logic          ge;
            for (int l = 0; l < NL; l++) begin
                t  = {w_rem[l][RW-2:0], w_nq[l][NW-1]};
                ge = (t >= {1'b0, w_div[l]});
                n_rem[l] = ge ? (t - {1'b0, w_div[l]}) : t;
                n_nq[l]  = {w_nq[l][NW-2:0], ge};
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ce) begin
                r_rem[gs]  <= n_rem;
                r_nq[gs]   <= n_nq;
                r_div[gs]  <= w_div;
                r_side[gs] <= w_side;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[gs] <= 1'b0;
            end else if (i_ce) begin
                r_v[gs] <= w_v;
            end
        end
    end

    assign o_valid = r_v[NW-1];
    assign o_quo   = r_nq[NW-1];
    assign o_rem   = r_rem[NW-1];
    assign o_div   = r_div[NW-1];
    assign o_side  = r_side[NW-1];

endmodule

@@ hw/rtl/p1the_back.sv @@
// ----------------------------------------------------------------------------
// p1the_back
// Rounding and sign, then entry sum, saturation (zero if degenerate) and the output register.
// ----------------------------------------------------------------------------
module p1the_back (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_ce,
    input  logic                                          i_valid,
    input  logic [p1the_pkg::NL-1:0][p1the_pkg::NW-1:0]   i_quo,
    input  logic [p1the_pkg::NL-1:0][p1the_pkg::RW-1:0]   i_rem,
    input  logic [p1the_pkg::NL-1:0][p1the_pkg::DVW-1:0]  i_div,
    input  p1the_pkg::t_side                              i_side,
    output logic                                          o_valid,
    output logic [p1the_pkg::NE-1:0][p1the_pkg::OW-1:0]   o_k,
    output logic                                          o_degen
);

    localparam int NW   = p1the_pkg::NW;
    localparam int NSL  = p1the_pkg::NSL;
    localparam int SSW  = p1the_pkg::SSW;
    localparam int SUMW = p1the_pkg::SUMW;
    localparam int OW   = p1the_pkg::OW;
    localparam int NE   = p1the_pkg::NE;

    // stage A
    logic signed [SSW-1:0] n_st [NSL], r_st [NSL];
    logic signed [SSW-1:0] n_ms [2], r_ms [2];
    logic r_degen_a, r_va;

    always_comb begin
        logic [NW:0]   mag;
        logic          rnd;
        logic [SSW-1:0] m;
        for (int k = 0; k < NSL; k++) begin
            rnd = ({i_rem[k], 1'b0} >= {2'b00, i_div[k]});
            mag = {1'b0, i_quo[k]} + (NW+1)'(rnd);
            m   = {1'b0, mag};
            n_st[k] = (i_side.gneg[k] ^ i_side.dneg) ? -m : m;
        end
        for (int k = 0; k < 2; k++) begin
            m = {{(SSW-p1the_pkg::QW){1'b0}}, i_side.mass[k]};
            n_ms[k] = i_side.dneg ? -m : m;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_st      <= n_st;
            r_ms      <= n_ms;
            r_degen_a <= i_side.degen;
        end
    end

    // stage B
    logic [NE-1:0][OW-1:0] n_k, r_k;
    logic r_degen, r_vb;

    always_comb begin
        logic signed [SUMW-1:0] s;
        for (int e = 0; e < NE; e++) begin
            s = {r_st[p1the_pkg::LANE_OF[e]][SSW-1], r_st[p1the_pkg::LANE_OF[e]]}
              + {r_ms[p1the_pkg::DIAG[e]][SSW-1], r_ms[p1the_pkg::DIAG[e]]};
            if (r_degen_a) begin
                n_k[e] = '0;
            end else if (s > p1the_pkg::SUM_MAX) begin
                n_k[e] = p1the_pkg::OUT_MAX;
            end else if (s < p1the_pkg::SUM_MIN) begin
                n_k[e] = p1the_pkg::OUT_MIN;
            end else begin
                n_k[e] = s[OW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_k     <= n_k;
            r_degen <= r_degen_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else if (i_ce) begin
            r_va <= i_valid;
            r_vb <= r_va;
        end
    end

    assign o_valid = r_vb;
    assign o_k     = r_k;
    assign o_degen = r_degen;

endmodule
